FILE: rtl/nmsdb_pkg.sv
package nmsdb_pkg;

	// Highest class number that a frame may hold.
	localparam int MAX_CLASSES = 255;

	// Default depth of the queue between parser and datapath.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_CLASS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd4;

	// Result kinds as seen on the output tuser.
	typedef enum logic [1:0] {
		KIND_DET = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// Operations handed from the parser to the datapath.
	typedef enum logic [1:0] {
		OP_COORD = 2'd0,
		OP_SCORE = 2'd1,
		OP_ERROR = 2'd2,
		OP_END   = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t    op;
		logic [1:0]  idx;       // coordinate slot for OP_COORD
		logic        last;      // the score word also closes the frame
		logic [7:0]  class_id;
		logic [15:0] word;
	} op_t;

	typedef struct packed {
		logic [7:0]         num_classes;
		logic [15:0]        max_per_class;
		logic [15:0]        zero_point;
		logic [31:0]        scale;
		logic signed [31:0] score_threshold;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         class_id;
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic signed [31:0] box_width;
		logic signed [31:0] box_height;
		logic [16:0]        confidence;
	} res_t;

	// Class count limited to one through MAX_CLASSES.
	function automatic logic [7:0] class_limit(input logic [7:0] n);
		logic [7:0] r;
		r = n;
		if (r > 8'(MAX_CLASSES)) r = 8'(MAX_CLASSES);
		if (r == 8'd0) r = 8'd1;
		return r;
	endfunction

endpackage

FILE: rtl/nmsdb_front.sv
module nmsdb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  nmsdb_pkg::cfg_t  cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // word
	input  logic             s_tuser,   // restart
	output logic             push,
	output nmsdb_pkg::op_t   push_op,
	input  logic             full
);
	import nmsdb_pkg::*;

	typedef enum logic [1:0] {
		PH_COUNT = 2'b01,
		PH_BOX   = 2'b10
	} phase_t;

	phase_t      phase_q, eff_phase, nxt_phase;
	logic [7:0]  class_q, eff_class, nxt_class, limit;
	logic [15:0] boxes_q, eff_boxes, nxt_boxes;
	logic [2:0]  pos_q, eff_pos, nxt_pos;
	logic        done_q, eff_done, nxt_done;
	logic        at_limit, push_c, accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && push_c;

	// Parser step: a restart word resets the section state before it is parsed.
	always_comb begin
		eff_phase = s_tuser ? PH_COUNT : phase_q;
		eff_class = s_tuser ? 8'd1 : class_q;
		eff_boxes = s_tuser ? 16'd0 : boxes_q;
		eff_pos   = s_tuser ? 3'd0 : pos_q;
		eff_done  = s_tuser ? 1'b0 : done_q;
		limit     = class_limit(cfg.num_classes);
		at_limit  = eff_class >= limit;

		nxt_phase = eff_phase;
		nxt_class = eff_class;
		nxt_boxes = eff_boxes;
		nxt_pos   = eff_pos;
		nxt_done  = eff_done;

		push_c           = 1'b0;
		push_op.op       = OP_COORD;
		push_op.idx      = eff_pos[1:0];
		push_op.last     = 1'b0;
		push_op.class_id = eff_class;
		push_op.word     = s_tdata;

		if (!eff_done) begin
			unique case (eff_phase)
				PH_COUNT: begin
					if (s_tdata > cfg.max_per_class) begin
						push_c     = 1'b1;
						push_op.op = OP_ERROR;
						nxt_done   = 1'b1;
					end else if (s_tdata == 16'd0) begin
						if (at_limit) begin
							push_c     = 1'b1;
							push_op.op = OP_END;
							nxt_done   = 1'b1;
						end else begin
							nxt_class = eff_class + 8'd1;
						end
					end else begin
						nxt_boxes = s_tdata;
						nxt_pos   = 3'd0;
						nxt_phase = PH_BOX;
					end
				end
				PH_BOX: begin
					push_c = 1'b1;
					if (eff_pos < 3'd4) begin
						push_op.op = OP_COORD;
						nxt_pos    = eff_pos + 3'd1;
					end else begin
						push_op.op   = OP_SCORE;
						push_op.last = (eff_boxes == 16'd1) && at_limit;
						nxt_pos      = 3'd0;
						nxt_boxes    = eff_boxes - 16'd1;
						if (eff_boxes == 16'd1) begin
							nxt_phase = PH_COUNT;
							if (at_limit) begin
								nxt_done = 1'b1;
							end else begin
								nxt_class = eff_class + 8'd1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Parser state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			class_q <= 8'd1;
			boxes_q <= 16'd0;
			pos_q   <= 3'd0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			class_q <= nxt_class;
			boxes_q <= nxt_boxes;
			pos_q   <= nxt_pos;
			done_q  <= nxt_done;
		end
	end

	// A finished or failed frame always leaves the parser waiting for a count.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == PH_COUNT)
		else $error("frame closed with parser inside a box");

	// Within a box the field position never passes the score slot.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BOX |-> pos_q <= 3'd4)
		else $error("field position out of range");

endmodule

FILE: rtl/nmsdb_fifo.sv
module nmsdb_fifo #(
	parameter int DEPTH = nmsdb_pkg::QUEUE_DEPTH_DEF   // 2 to 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nmsdb_pkg::op_t  push_op,
	output logic            full,
	input  logic            pop,
	output nmsdb_pkg::op_t  pop_op,
	output logic            empty
);
	import nmsdb_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign pop_op = mem_q[rd_q];

	// Entry storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_op;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH) && !(pop && empty))
		else $error("queue over- or underflow");

endmodule

FILE: rtl/nmsdb_back.sv
module nmsdb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  nmsdb_pkg::cfg_t cfg,
	input  nmsdb_pkg::op_t  op,
	input  logic            empty,
	output logic            pop,
	output nmsdb_pkg::res_t res,
	output logic            m_tvalid,
	input  logic            m_tready
);
	import nmsdb_pkg::*;

	logic               adv;
	logic signed [16:0] diff_c;
	logic [15:0]        mag_c;
	logic [47:0]        prod_c;

	logic               valid_s1, neg_s1;
	logic [47:0]        prod_s1;
	op_t                op_s1;

	logic [48:0]        sum_c;
	logic [40:0]        rnd_c;
	logic [31:0]        dq_c;

	logic               valid_s2;
	logic signed [31:0] dq_s2;
	op_t                op_s2;

	logic signed [31:0] held_q [4];

	logic               det_c, load_c, pend_c;
	logic signed [32:0] wdiff_c, hdiff_c;
	res_t               new_c, end_c, res_q;
	logic               res_valid_q, end_pend_q;

	// The whole pipeline moves when the result register can take a new item.
	assign adv      = !res_valid_q || (m_tready && !end_pend_q);
	assign pop      = adv && !empty;
	assign res      = res_q;
	assign m_tvalid = res_valid_q;

	// Stage 1: subtract the zero point and multiply the magnitude by the scale.
	assign diff_c = $signed({1'b0, op.word}) - $signed({1'b0, cfg.zero_point});
	assign mag_c  = diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
	assign prod_c = mag_c * cfg.scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !empty;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_c;
			neg_s1  <= diff_c[16];
			op_s1   <= op;
			dq_s2   <= $signed(dq_c);
			op_s2   <= op_s1;
		end
	end

	// Stage 2: round to nearest with ties away from zero, then saturate.
	assign sum_c = {1'b0, prod_s1} + 49'd128;
	assign rnd_c = sum_c[48:8];

	always_comb begin
		if (!neg_s1) begin
			dq_c = (|rnd_c[40:31]) ? 32'h7FFF_FFFF : rnd_c[31:0];
		end else if ((|rnd_c[40:32]) || (rnd_c[31] && (|rnd_c[30:0]))) begin
			dq_c = 32'h8000_0000;
		end else begin
			dq_c = -rnd_c[31:0];
		end
	end

	// Coordinates of the current box are held until its score arrives.
	always_ff @(posedge clk) begin
		if (adv && valid_s2 && op_s2.op == OP_COORD) held_q[op_s2.idx] <= dq_s2;
	end

	// Result assembly from the score and the held coordinates.
	assign wdiff_c = {held_q[3][31], held_q[3]} - {held_q[1][31], held_q[1]};
	assign hdiff_c = {held_q[2][31], held_q[2]} - {held_q[0][31], held_q[0]};

	always_comb begin
		end_c          = '0;
		end_c.kind     = KIND_END;
		new_c          = end_c;
		det_c          = dq_s2 > cfg.score_threshold;
		load_c         = 1'b0;
		pend_c         = 1'b0;
		case (op_s2.op)
			OP_SCORE: begin
				if (det_c) begin
					load_c           = 1'b1;
					pend_c           = op_s2.last;
					new_c.kind       = KIND_DET;
					new_c.class_id   = op_s2.class_id;
					new_c.left       = held_q[1];
					new_c.top        = held_q[0];
					new_c.box_width  = (wdiff_c[32] != wdiff_c[31]) ?
						(wdiff_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : wdiff_c[31:0];
					new_c.box_height = (hdiff_c[32] != hdiff_c[31]) ?
						(hdiff_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hdiff_c[31:0];
					if (dq_s2 < 0) begin
						new_c.confidence = 17'd0;
					end else if (dq_s2 > 32'sd65536) begin
						new_c.confidence = 17'd65536;
					end else begin
						new_c.confidence = dq_s2[16:0];
					end
				end else begin
					load_c = op_s2.last;
				end
			end
			OP_ERROR: begin
				load_c         = 1'b1;
				new_c.kind     = KIND_ERR;
				new_c.class_id = op_s2.class_id;
			end
			OP_END: begin
				load_c = 1'b1;
			end
			default: ;
		endcase
	end

	// Output register; a detection that closes the frame is followed by frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			end_pend_q  <= 1'b0;
		end else if (adv && valid_s2 && load_c) begin
			res_valid_q <= 1'b1;
			end_pend_q  <= pend_c;
		end else if (res_valid_q && m_tready) begin
			if (end_pend_q) begin
				end_pend_q <= 1'b0;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_q && m_tready && end_pend_q) begin
			res_q <= end_c;
		end else if (adv && valid_s2 && load_c) begin
			res_q <= new_c;
		end
	end

	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		end_pend_q |-> res_valid_q)
		else $error("pending frame end without a held result");

endmodule

FILE: rtl/nms_detection_buffer_decoder.sv
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tdata: word; tuser: restart
// m_*       out        m_tvalid / m_tready   tdata: class_id..confidence; tuser: kind
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input word is taken per cycle while s_tready is high; a score word that both detects a box and closes
// the frame gives two results and holds the output register until the frame end result is also taken.
// A result follows its input transfer through the queue, then queue read with
// multiply, round and the result register.
// Reset clears the parser, the queue and the output register; configuration registers
// return to their documented values. cfg_ready is always high.
// A stalled output stops the datapath; the queue then fills and drops s_tready.
module nms_detection_buffer_decoder #(
	parameter int QUEUE_DEPTH = nmsdb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // [15:0] word
	input  logic                              s_tuser,   // [0] restart
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] class_id, [39:8] left, [71:40] top, [103:72] box_width,
	// [135:104] box_height, [152:136] confidence, [159:153] zero
	output logic [159:0]                      m_tdata,
	output logic [1:0]                        m_tuser,   // [1:0] kind
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nmsdb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data
);
	import nmsdb_pkg::*;

	cfg_t  cfg_q;
	logic  push, full, pop, empty;
	op_t   push_op, pop_op;
	res_t  res;

	assign cfg_ready = 1'b1;

	// Configuration registers, written one per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_classes     <= 8'd90;
			cfg_q.max_per_class   <= 16'd100;
			cfg_q.zero_point      <= 16'd0;
			cfg_q.scale           <= 32'd0;
			cfg_q.score_threshold <= 32'sd26214;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUM_CLASSES:     cfg_q.num_classes     <= cfg_data[7:0];
				REG_MAX_PER_CLASS:   cfg_q.max_per_class   <= cfg_data[15:0];
				REG_ZERO_POINT:      cfg_q.zero_point      <= cfg_data[15:0];
				REG_SCALE:           cfg_q.scale           <= cfg_data;
				REG_SCORE_THRESHOLD: cfg_q.score_threshold <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	nmsdb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_op  (push_op),
		.full     (full)
	);

	nmsdb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (empty)
	);

	nmsdb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op       (pop_op),
		.empty    (empty),
		.pop      (pop),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	// Output packing, first field in the lowest bits.
	assign m_tuser = res.kind;
	assign m_tdata = {7'd0, res.confidence, res.box_height, res.box_width,
		res.top, res.left, res.class_id};

endmodule
